### sv/tgq_pkg.sv
package tgq_pkg;

	localparam int FRAC_BITS_DEF    = 16;
	localparam int FRAME_BITS_DEF   = 48;
	localparam int MAX_GRID_DIV_DEF = 8;

	localparam int UNIT_W  = 64;
	localparam int RATE_W  = 19;
	localparam int TEMPO_W = 17;
	localparam int BEATS_W = 5;
	localparam int DIV_W   = 4;
	localparam int FACT_W  = 5;
	localparam int PROD_W  = 32;
	localparam int DEN_W   = TEMPO_W + FACT_W;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;

	localparam logic [PROD_W-1:0]  CENTI_SEC = PROD_W'(6000);
	localparam logic [BEATS_W-1:0] BEATS_CAP = BEATS_W'(16);

	localparam logic [RATE_W-1:0]  RATE_RST   = RATE_W'(44100);
	localparam logic [TEMPO_W-1:0] TEMPO_RST  = TEMPO_W'(12000);
	localparam logic [TEMPO_W-1:0] T_LO_RST   = TEMPO_W'(2000);
	localparam logic [TEMPO_W-1:0] T_HI_RST   = TEMPO_W'(30000);
	localparam logic [BEATS_W-1:0] BEATS_RST  = BEATS_W'(4);
	localparam logic [DIV_W-1:0]   DIV_RST    = DIV_W'(1);

	typedef logic [2:0] reg_idx_t;
	localparam reg_idx_t REG_RATE  = 3'd0;
	localparam reg_idx_t REG_TEMPO = 3'd1;
	localparam reg_idx_t REG_T_LO  = 3'd2;
	localparam reg_idx_t REG_T_HI  = 3'd3;
	localparam reg_idx_t REG_BEATS = 3'd4;
	localparam reg_idx_t REG_DIV   = 3'd5;

	typedef enum logic [1:0] {
		REQ_SNAP = 2'd0,
		REQ_FWD  = 2'd1,
		REQ_BACK = 2'd2,
		REQ_PASS = 2'd3
	} req_t;

	typedef enum logic [1:0] {
		UC_IDLE,
		UC_MUL,
		UC_LOAD,
		UC_DIV
	} uc_state_t;

	typedef struct packed {
		logic vld;
		req_t req;
	} item_ctl_t;

	typedef struct packed {
		logic [RATE_W-1:0]  rate;
		logic [TEMPO_W-1:0] tempo;
		logic [TEMPO_W-1:0] t_lo;
		logic [TEMPO_W-1:0] t_hi;
		logic [BEATS_W-1:0] beats;
		logic [DIV_W-1:0]   div;
	} cfg_t;

endpackage

### sv/tgq_unit_calc.sv
module tgq_unit_calc #(
	parameter int FRAC_BITS    = tgq_pkg::FRAC_BITS_DEF,
	parameter int MAX_GRID_DIV = tgq_pkg::MAX_GRID_DIV_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        go,
	input  tgq_pkg::cfg_t               cfg,
	output logic                        busy,
	output logic [tgq_pkg::UNIT_W-1:0]  unit
);

	localparam int NUM_W = tgq_pkg::PROD_W + tgq_pkg::FACT_W + FRAC_BITS;
	localparam int CNT_W = $clog2(NUM_W + 1);
	localparam int QX_W  = NUM_W + tgq_pkg::UNIT_W;
	localparam int MUL_W = NUM_W - FRAC_BITS;

	tgq_pkg::uc_state_t state_q, state_d;
	logic                         pend_q;
	logic [tgq_pkg::PROD_W-1:0]   prod_q;
	logic [tgq_pkg::FACT_W-1:0]   fact_q;
	logic [tgq_pkg::DEN_W-1:0]    den_q;
	logic                         zero_q;
	logic [NUM_W-1:0]             num_q;
	logic [NUM_W-1:0]             quo_q;
	logic [tgq_pkg::DEN_W-1:0]    rem_q;
	logic [CNT_W-1:0]             cnt_q;
	logic [tgq_pkg::UNIT_W-1:0]   unit_q;

	logic [tgq_pkg::TEMPO_W-1:0]  tclamp;
	logic                         bad;
	logic [tgq_pkg::BEATS_W-1:0]  beats_eff;
	logic [tgq_pkg::FACT_W-1:0]   div_eff;
	logic [tgq_pkg::FACT_W-1:0]   fact;
	logic [tgq_pkg::FACT_W-1:0]   den_mul;
	logic [tgq_pkg::DEN_W:0]      t_step;
	logic                         ge;
	logic [tgq_pkg::DEN_W-1:0]    rem_n;
	logic [NUM_W-1:0]             quo_n;
	logic [QX_W-1:0]              qx;
	logic                         do_mul, do_load, do_step, last;

	always_comb begin
		if (cfg.tempo < cfg.t_lo) begin
			tclamp = cfg.t_lo;
		end else if (cfg.tempo > cfg.t_hi) begin
			tclamp = cfg.t_hi;
		end else begin
			tclamp = cfg.tempo;
		end
		bad = (cfg.rate == '0) || (tclamp == '0) || (tclamp < cfg.t_lo) || (tclamp > cfg.t_hi);
		beats_eff = (cfg.beats > tgq_pkg::BEATS_CAP) ? tgq_pkg::BEATS_CAP : cfg.beats;
		if ({1'b0, cfg.div} > tgq_pkg::FACT_W'(MAX_GRID_DIV)) begin
			div_eff = tgq_pkg::FACT_W'(MAX_GRID_DIV);
		end else begin
			div_eff = {1'b0, cfg.div};
		end
		if (div_eff == '0) begin
			fact    = (beats_eff >= tgq_pkg::BEATS_W'(2)) ? beats_eff : tgq_pkg::FACT_W'(1);
			den_mul = tgq_pkg::FACT_W'(1);
		end else begin
			fact    = tgq_pkg::FACT_W'(1);
			den_mul = div_eff;
		end
	end

	always_comb begin
		t_step = {rem_q, num_q[NUM_W-1]};
		ge     = t_step >= {1'b0, den_q};
		rem_n  = ge ? tgq_pkg::DEN_W'(t_step - {1'b0, den_q}) : t_step[tgq_pkg::DEN_W-1:0];
		quo_n  = {quo_q[NUM_W-2:0], ge};
		qx     = QX_W'(quo_n);
	end

	always_comb begin
		state_d = state_q;
		do_mul  = 1'b0;
		do_load = 1'b0;
		do_step = 1'b0;
		last    = 1'b0;
		unique case (state_q)
			tgq_pkg::UC_IDLE: begin
				if (pend_q) begin
					state_d = tgq_pkg::UC_MUL;
				end
			end
			tgq_pkg::UC_MUL: begin
				do_mul  = 1'b1;
				state_d = tgq_pkg::UC_LOAD;
			end
			tgq_pkg::UC_LOAD: begin
				do_load = 1'b1;
				state_d = tgq_pkg::UC_DIV;
			end
			tgq_pkg::UC_DIV: begin
				do_step = 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					last    = 1'b1;
					state_d = tgq_pkg::UC_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= tgq_pkg::UC_IDLE;
			pend_q  <= 1'b1;
			cnt_q   <= '0;
			unit_q  <= '0;
		end else begin
			state_q <= state_d;
			if (go) begin
				pend_q <= 1'b1;
			end else if (state_q == tgq_pkg::UC_IDLE) begin
				pend_q <= 1'b0;
			end
			if (do_load) begin
				cnt_q <= CNT_W'(NUM_W);
			end else if (do_step) begin
				cnt_q <= cnt_q - CNT_W'(1);
			end
			if (last) begin
				if (zero_q) begin
					unit_q <= '0;
				end else if (|qx[QX_W-1:tgq_pkg::UNIT_W]) begin
					unit_q <= '1;
				end else begin
					unit_q <= qx[tgq_pkg::UNIT_W-1:0];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_mul) begin
			prod_q <= tgq_pkg::PROD_W'(cfg.rate) * tgq_pkg::CENTI_SEC;
			fact_q <= fact;
			den_q  <= tgq_pkg::DEN_W'(tclamp) * tgq_pkg::DEN_W'(den_mul);
			zero_q <= bad;
		end
		if (do_load) begin
			num_q <= {MUL_W'(prod_q) * MUL_W'(fact_q), {FRAC_BITS{1'b0}}};
			quo_q <= '0;
			rem_q <= '0;
		end else if (do_step) begin
			num_q <= {num_q[NUM_W-2:0], 1'b0};
			quo_q <= quo_n;
			rem_q <= rem_n;
		end
	end

	assign busy = pend_q || (state_q != tgq_pkg::UC_IDLE);
	assign unit = unit_q;

endmodule

### sv/tgq_div_cell.sv
module tgq_div_cell #(
	parameter int FRAME_BITS = tgq_pkg::FRAME_BITS_DEF,
	parameter int DW         = 65
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [tgq_pkg::UNIT_W-1:0]  unit,
	input  tgq_pkg::item_ctl_t          ctl_in,
	input  logic [FRAME_BITS-1:0]       frame_in,
	input  logic [DW-1:0]               num_in,
	input  logic [tgq_pkg::UNIT_W-1:0]  rem_in,
	output tgq_pkg::item_ctl_t          ctl_out,
	output logic [FRAME_BITS-1:0]       frame_out,
	output logic [DW-1:0]               num_out,
	output logic [tgq_pkg::UNIT_W-1:0]  rem_out
);

	tgq_pkg::item_ctl_t           ctl_s1;
	logic [FRAME_BITS-1:0]        frame_s1;
	logic [DW-1:0]                num_s1;
	logic [tgq_pkg::UNIT_W-1:0]   rem_s1;

	logic [tgq_pkg::UNIT_W:0]     t_step;
	logic [tgq_pkg::UNIT_W:0]     diff;
	logic [tgq_pkg::UNIT_W-1:0]   rem_n;

	always_comb begin
		t_step = {rem_in, num_in[DW-1]};
		diff   = t_step - {1'b0, unit};
		rem_n  = (t_step >= {1'b0, unit}) ? diff[tgq_pkg::UNIT_W-1:0]
		                                  : t_step[tgq_pkg::UNIT_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		frame_s1 <= frame_in;
		num_s1   <= {num_in[DW-2:0], 1'b0};
		rem_s1   <= rem_n;
	end

	assign ctl_out   = ctl_s1;
	assign frame_out = frame_s1;
	assign num_out   = num_s1;
	assign rem_out   = rem_s1;

endmodule

### sv/tempo_grid_frame_quantizer_unit.sv
// Tempo grid frame quantizer.
// Requests: drive req_type and frame_in with start high; the request is taken
// at the rising edge where start is high and busy is low. Codes: snap to the
// nearest grid line, step forward, step back, or pass the frame through.
// Results: done is high for one cycle with frame_out and grid_active; the
// receiver cannot hold them off. Each request takes one restoring division
// step per cell along the chain, then three stages that rebuild, round and
// saturate the grid line.
// Throughput: one request per clock while busy is low; the chain holds every
// request in flight.
// Configuration: APB registers at byte addresses 0,4,..,20. After each write,
// and after reset, busy stays high while the grid spacing is recomputed by a
// one-bit-per-cycle divider. Reset clears the chain, restores the register
// defaults and starts that recomputation; no request is taken until it ends.
module tempo_grid_frame_quantizer_unit #(
	parameter int FRAC_BITS    = tgq_pkg::FRAC_BITS_DEF,
	parameter int FRAME_BITS   = tgq_pkg::FRAME_BITS_DEF,
	parameter int MAX_GRID_DIV = tgq_pkg::MAX_GRID_DIV_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tgq_pkg::ADDR_W-1:0]  paddr,
	input  logic [tgq_pkg::DATA_W-1:0]  pwdata,
	output logic [tgq_pkg::DATA_W-1:0]  prdata,
	output logic                        pready,
	input  logic                        start,
	output logic                        busy,
	input  logic [1:0]                  req_type,
	input  logic [FRAME_BITS-1:0]       frame_in,
	output logic                        done,
	output logic [FRAME_BITS-1:0]       frame_out,
	output logic                        grid_active
);

	localparam int FF       = FRAME_BITS + FRAC_BITS;
	localparam int DW       = ((FF > tgq_pkg::UNIT_W) ? FF : tgq_pkg::UNIT_W) + 1;
	localparam int PW       = DW + 1;
	localparam int PIPE_LAT = DW + 4;
	localparam logic [PW:0] HALF = {{PW{1'b0}}, 1'b1} << (FRAC_BITS - 1);

	tgq_pkg::cfg_t                cfg_q;
	tgq_pkg::reg_idx_t            idx;
	logic                         wr;
	logic                         calc_busy;
	logic [tgq_pkg::UNIT_W-1:0]   unit;
	logic                         accept;
	tgq_pkg::req_t                req_in;

	tgq_pkg::item_ctl_t           ctl_s0;
	logic [FRAME_BITS-1:0]        frame_s0;
	logic [DW-1:0]                num_s0;
	logic [DW-1:0]                x0;

	tgq_pkg::item_ctl_t           ctl_c   [DW+1];
	logic [FRAME_BITS-1:0]        frame_c [DW+1];
	logic [DW-1:0]                num_c   [DW+1];
	logic [tgq_pkg::UNIT_W-1:0]   rem_c   [DW+1];

	logic [PW-1:0]                x1, u1, h1, r1, prod_n;
	tgq_pkg::item_ctl_t           ctl_s1;
	logic [FRAME_BITS-1:0]        frame_s1;
	logic [PW-1:0]                prod_s1;

	logic [PW:0]                  pos1, frame_x;
	logic [PW-1:0]                alt_n;
	logic                         sel_n, zero_n;
	tgq_pkg::item_ctl_t           ctl_s2;
	logic [FRAME_BITS-1:0]        frame_s2;
	logic [PW:0]                  pos_s2;
	logic [PW-1:0]                alt_s2;
	logic                         sel_s2, zero_s2;

	logic [PW:0]                  pos_alt, pick;
	logic [FRAME_BITS-1:0]        res_n;
	logic                         done_q;
	logic [FRAME_BITS-1:0]        frame_out_q;
	logic                         grid_q;

	assign idx    = paddr[tgq_pkg::ADDR_W-1:2];
	assign wr     = psel && penable && pwrite;
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.rate  <= tgq_pkg::RATE_RST;
			cfg_q.tempo <= tgq_pkg::TEMPO_RST;
			cfg_q.t_lo  <= tgq_pkg::T_LO_RST;
			cfg_q.t_hi  <= tgq_pkg::T_HI_RST;
			cfg_q.beats <= tgq_pkg::BEATS_RST;
			cfg_q.div   <= tgq_pkg::DIV_RST;
		end else if (wr) begin
			unique case (idx)
				tgq_pkg::REG_RATE:  cfg_q.rate  <= pwdata[tgq_pkg::RATE_W-1:0];
				tgq_pkg::REG_TEMPO: cfg_q.tempo <= pwdata[tgq_pkg::TEMPO_W-1:0];
				tgq_pkg::REG_T_LO:  cfg_q.t_lo  <= pwdata[tgq_pkg::TEMPO_W-1:0];
				tgq_pkg::REG_T_HI:  cfg_q.t_hi  <= pwdata[tgq_pkg::TEMPO_W-1:0];
				tgq_pkg::REG_BEATS: cfg_q.beats <= pwdata[tgq_pkg::BEATS_W-1:0];
				tgq_pkg::REG_DIV:   cfg_q.div   <= pwdata[tgq_pkg::DIV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			tgq_pkg::REG_RATE:  prdata = tgq_pkg::DATA_W'(cfg_q.rate);
			tgq_pkg::REG_TEMPO: prdata = tgq_pkg::DATA_W'(cfg_q.tempo);
			tgq_pkg::REG_T_LO:  prdata = tgq_pkg::DATA_W'(cfg_q.t_lo);
			tgq_pkg::REG_T_HI:  prdata = tgq_pkg::DATA_W'(cfg_q.t_hi);
			tgq_pkg::REG_BEATS: prdata = tgq_pkg::DATA_W'(cfg_q.beats);
			tgq_pkg::REG_DIV:   prdata = tgq_pkg::DATA_W'(cfg_q.div);
			default:            prdata = '0;
		endcase
	end

	tgq_unit_calc #(
		.FRAC_BITS    (FRAC_BITS),
		.MAX_GRID_DIV (MAX_GRID_DIV)
	) u_unit_calc (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (wr),
		.cfg    (cfg_q),
		.busy   (calc_busy),
		.unit   (unit)
	);

	assign busy   = calc_busy || (psel && pwrite);
	assign accept = start && !busy;
	assign req_in = tgq_pkg::req_t'(req_type);
	assign x0     = DW'({frame_in, {FRAC_BITS{1'b0}}});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s0 <= '0;
		end else begin
			ctl_s0.vld <= accept;
			ctl_s0.req <= req_in;
		end
	end

	always_ff @(posedge clk) begin
		frame_s0 <= frame_in;
		num_s0   <= (req_in == tgq_pkg::REQ_SNAP) ? x0 + DW'(unit >> 1) : x0;
	end

	assign ctl_c[0]   = ctl_s0;
	assign frame_c[0] = frame_s0;
	assign num_c[0]   = num_s0;
	assign rem_c[0]   = '0;

	for (genvar i = 0; i < DW; i++) begin : g_cell
		tgq_div_cell #(
			.FRAME_BITS (FRAME_BITS),
			.DW         (DW)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.unit      (unit),
			.ctl_in    (ctl_c[i]),
			.frame_in  (frame_c[i]),
			.num_in    (num_c[i]),
			.rem_in    (rem_c[i]),
			.ctl_out   (ctl_c[i+1]),
			.frame_out (frame_c[i+1]),
			.num_out   (num_c[i+1]),
			.rem_out   (rem_c[i+1])
		);
	end

	always_comb begin
		x1 = PW'({frame_c[DW], {FRAC_BITS{1'b0}}});
		u1 = PW'(unit);
		h1 = PW'(unit >> 1);
		r1 = PW'(rem_c[DW]);
		unique case (ctl_c[DW].req)
			tgq_pkg::REQ_SNAP: prod_n = x1 + h1 - r1;
			tgq_pkg::REQ_FWD:  prod_n = x1 - r1 + u1;
			tgq_pkg::REQ_BACK: prod_n = (rem_c[DW] == '0) ? x1 - u1 : x1 - r1;
			tgq_pkg::REQ_PASS: prod_n = x1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			done_q <= 1'b0;
		end else begin
			ctl_s1 <= ctl_c[DW];
			ctl_s2 <= ctl_s1;
			done_q <= ctl_s2.vld;
		end
	end

	always_ff @(posedge clk) begin
		frame_s1 <= frame_c[DW];
		prod_s1  <= prod_n;
	end

	always_comb begin
		pos1    = ({1'b0, prod_s1} + HALF) >> FRAC_BITS;
		frame_x = (PW+1)'(frame_s1);
		alt_n   = prod_s1;
		sel_n   = 1'b0;
		zero_n  = 1'b0;
		case (ctl_s1.req)
			tgq_pkg::REQ_FWD: begin
				alt_n = prod_s1 + PW'(unit);
				sel_n = pos1 <= frame_x;
			end
			tgq_pkg::REQ_BACK: begin
				alt_n  = prod_s1 - PW'(unit);
				sel_n  = (pos1 >= frame_x) && (prod_s1 != '0);
				zero_n = (frame_s1 == '0) || ((pos1 >= frame_x) && (prod_s1 == '0));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		frame_s2 <= frame_s1;
		pos_s2   <= pos1;
		alt_s2   <= alt_n;
		sel_s2   <= sel_n;
		zero_s2  <= zero_n;
	end

	always_comb begin
		pos_alt = ({1'b0, alt_s2} + HALF) >> FRAC_BITS;
		pick    = sel_s2 ? pos_alt : pos_s2;
		if ((unit == '0) || (ctl_s2.req == tgq_pkg::REQ_PASS)) begin
			res_n = frame_s2;
		end else if (zero_s2) begin
			res_n = '0;
		end else if (|pick[PW:FRAME_BITS]) begin
			res_n = '1;
		end else begin
			res_n = pick[FRAME_BITS-1:0];
		end
	end

	always_ff @(posedge clk) begin
		frame_out_q <= res_n;
		grid_q      <= (unit != '0);
	end

	assign done        = done_q;
	assign frame_out   = frame_out_q;
	assign grid_active = grid_q;

endmodule

### sv/tgq_checker.sv
module tgq_checker #(
	parameter int LAT = 69
) (
	input logic clk,
	input logic arst_n,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic pready,
	input logic start,
	input logic busy,
	input logic done
);

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##LAT done)
		else $error("accepted beat produced no result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LAT))
		else $error("result without an accepted beat");

	a_cfg_recalc: assert property (@(posedge clk) disable iff (!arst_n)
		psel && penable && pwrite && pready |=> busy)
		else $error("register write did not hold off requests");

endmodule

bind tempo_grid_frame_quantizer_unit tgq_checker #(.LAT(PIPE_LAT)) u_tgq_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.psel    (psel),
	.penable (penable),
	.pwrite  (pwrite),
	.pready  (pready),
	.start   (start),
	.busy    (busy),
	.done    (done)
);

### bench/tb_tempo_grid_frame_quantizer_unit.sv
module tb_tempo_grid_frame_quantizer_unit;
	import tgq_pkg::*;

	localparam int FB = FRAME_BITS_DEF;
	localparam int FR = FRAC_BITS_DEF;
	localparam logic [FB-1:0] FRAME_MAX = {FB{1'b1}};
	localparam int DRAIN_CYCLES = 80;

	typedef struct {
		logic [FB-1:0] frame;
		logic          active;
	} grid_hit_t;

	logic                clk;
	logic                arst_n;
	logic                psel;
	logic                penable;
	logic                pwrite;
	logic [ADDR_W-1:0]   paddr;
	logic [DATA_W-1:0]   pwdata;
	logic [DATA_W-1:0]   prdata;
	logic                pready;
	logic                start;
	logic                busy;
	logic [1:0]          req_type;
	logic [FB-1:0]       frame_in;
	logic                done;
	logic [FB-1:0]       frame_out;
	logic                grid_active;

	logic [RATE_W-1:0]   m_rate;
	logic [TEMPO_W-1:0]  m_tempo;
	logic [TEMPO_W-1:0]  m_t_lo;
	logic [TEMPO_W-1:0]  m_t_hi;
	logic [BEATS_W-1:0]  m_beats;
	logic [DIV_W-1:0]    m_div;

	grid_hit_t pending_hits[$];
	int mismatches;
	int burst_left;

	tempo_grid_frame_quantizer_unit u_dut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.start(start), .busy(busy), .req_type(req_type), .frame_in(frame_in),
		.done(done), .frame_out(frame_out), .grid_active(grid_active)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("Verification failed");
		$finish;
	end

	function automatic logic [63:0] grid_spacing();
		logic [63:0]  t;
		logic [63:0]  num;
		logic [63:0]  den;
		logic [63:0]  bts;
		logic [63:0]  dv;
		logic [127:0] q;
		t = m_tempo;
		if (t < m_t_lo) t = m_t_lo;
		else if (t > m_t_hi) t = m_t_hi;
		if (m_rate == 0 || t == 0 || t < m_t_lo || t > m_t_hi) return 64'd0;
		bts = (m_beats > 16) ? 64'd16 : 64'(m_beats);
		dv = (m_div > MAX_GRID_DIV_DEF) ? 64'(MAX_GRID_DIV_DEF) : 64'(m_div);
		num = 64'd6000 * 64'(m_rate);
		den = t;
		if (dv == 0) begin
			if (bts >= 2) num = num * bts;
		end else begin
			den = den * dv;
		end
		q = {64'd0, num} << FR;
		q = q / {64'd0, den};
		return (q[127:64] != 0) ? {64{1'b1}} : q[63:0];
	endfunction

	function automatic logic [127:0] line_pos(logic [127:0] k, logic [63:0] u);
		return (k * {64'd0, u} + (128'd1 << (FR - 1))) >> FR;
	endfunction

	function automatic logic [FB-1:0] clip(logic [127:0] p);
		return (p > {80'd0, FRAME_MAX}) ? FRAME_MAX : p[FB-1:0];
	endfunction

	function automatic grid_hit_t predict_grid_hit(req_t rq, logic [FB-1:0] f);
		grid_hit_t    h;
		logic [63:0]  u;
		logic [127:0] x;
		logic [127:0] k;
		logic [127:0] p;
		logic [127:0] f128;
		u = grid_spacing();
		h.active = (u != 0);
		h.frame = f;
		f128 = {80'd0, f};
		if (u == 0 || rq == REQ_PASS) return h;
		x = f128 << FR;
		case (rq)
			REQ_SNAP: begin
				k = (x + {64'd0, u >> 1}) / {64'd0, u};
				h.frame = clip(line_pos(k, u));
			end
			REQ_FWD: begin
				k = x / {64'd0, u} + 1;
				p = line_pos(k, u);
				if (p <= f128) p = line_pos(k + 1, u);
				h.frame = clip(p);
			end
			default: begin
				if (f == 0) begin
					h.frame = '0;
				end else begin
					k = x / {64'd0, u};
					if (x % {64'd0, u} == 0) k = k - 1;
					p = line_pos(k, u);
					if (p >= f128) begin
						if (k == 0) p = '0;
						else p = line_pos(k - 1, u);
					end
					h.frame = clip(p);
				end
			end
		endcase
		return h;
	endfunction

	always @(posedge clk) begin
		grid_hit_t h;
		if (done) begin
			if (pending_hits.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected beat: frame_out=%0d grid_active=%0b",
						frame_out, grid_active);
			end else begin
				h = pending_hits.pop_front();
				if (frame_out !== h.frame || grid_active !== h.active) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp frame %0d active %0b, got frame %0d active %0b",
							h.frame, h.active, frame_out, grid_active);
				end
			end
		end
	end

	task automatic reg_write(reg_idx_t idx, logic [DATA_W-1:0] val);
		@(negedge clk);
		psel = 1'b1; penable = 1'b0; pwrite = 1'b1;
		paddr = ADDR_W'(idx) << 2; pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
		case (idx)
			REG_RATE:  m_rate  = val[RATE_W-1:0];
			REG_TEMPO: m_tempo = val[TEMPO_W-1:0];
			REG_T_LO:  m_t_lo  = val[TEMPO_W-1:0];
			REG_T_HI:  m_t_hi  = val[TEMPO_W-1:0];
			REG_BEATS: m_beats = val[BEATS_W-1:0];
			default:   m_div   = val[DIV_W-1:0];
		endcase
	endtask

	task automatic settle();
		wait (pending_hits.size() == 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic set_grid(int rate, int tempo, int lo, int hi, int bts, int dv);
		settle();
		reg_write(REG_RATE, rate);
		reg_write(REG_TEMPO, tempo);
		reg_write(REG_T_LO, lo);
		reg_write(REG_T_HI, hi);
		reg_write(REG_BEATS, bts);
		reg_write(REG_DIV, dv);
	endtask

	// drive at negedge; busy is stable there, so the next edge accepts when it is low
	task automatic send_req(req_t rq, logic [FB-1:0] f);
		if (burst_left == 0) begin
			@(negedge clk);
			start = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 12) : 0) @(negedge clk);
			burst_left = $urandom_range(1, 20);
		end else begin
			@(negedge clk);
		end
		start = 1'b1;
		req_type = rq;
		frame_in = f;
		while (busy) @(negedge clk);
		@(posedge clk);
		pending_hits.push_back(predict_grid_hit(rq, f));
		burst_left--;
	endtask

	task automatic end_burst();
		@(negedge clk);
		start = 1'b0;
		burst_left = 0;
	endtask

	function automatic logic [FB-1:0] pick_frame();
		logic [63:0]  u;
		logic [127:0] k;
		logic [127:0] p;
		u = grid_spacing();
		case ($urandom_range(0, 5))
			0: return FB'({$urandom(), $urandom()});
			1: return FRAME_MAX - FB'($urandom_range(0, 1000));
			2: return FB'($urandom_range(0, 3));
			default: begin
				k = $urandom_range(0, 3) == 0 ? {96'd0, $urandom()} : $urandom_range(0, 200);
				p = line_pos(k, u) + $urandom_range(0, 4) - 2;
				return clip(p);
			end
		endcase
	endfunction

	function automatic req_t pick_req();
		int r;
		r = $urandom_range(0, 15);
		return (r == 0) ? REQ_PASS : req_t'(r % 3);
	endfunction

	task automatic test_directed();
		req_t rq;
		send_req(REQ_SNAP, '0);
		send_req(REQ_BACK, '0);
		send_req(REQ_FWD, '0);
		send_req(REQ_PASS, 48'h1234_5678_9ABC);
		send_req(REQ_SNAP, FRAME_MAX);
		send_req(REQ_FWD, FRAME_MAX);
		send_req(REQ_BACK, FRAME_MAX);
		send_req(REQ_FWD, FRAME_MAX - 10);
		send_req(REQ_SNAP, 48'd11025);
		send_req(REQ_SNAP, 48'd11024);
		send_req(REQ_FWD, 48'd22050);
		send_req(REQ_BACK, 48'd22050);
		send_req(REQ_BACK, 48'd22051);
		send_req(REQ_BACK, 48'd1);
		send_req(REQ_FWD, 48'hAAAA_AAAA_AAAA);
		send_req(REQ_BACK, 48'h5555_5555_5555);
		end_burst();
	endtask

	task automatic test_extreme_settings();
		// huge spacing, sub-frame spacing, empty tempo window, zero rate, top rate and tempo
		set_grid(384000, 1, 1, 99999, 16, 0);
		for (int i = 0; i < 6; i++) send_req(req_t'(i % 4), i[0] ? FRAME_MAX : 48'd5);
		end_burst();
		set_grid(1, 99999, 1, 99999, 0, 8);
		for (int i = 0; i < 6; i++) send_req(req_t'(i % 3), FB'(i));
		end_burst();
		set_grid(48000, 12000, 30000, 2000, 1, 15);
		send_req(REQ_SNAP, 48'd777);
		send_req(REQ_FWD, 48'd777);
		end_burst();
		set_grid(0, 0, 0, 0, 31, 0);
		send_req(REQ_BACK, 48'd777);
		send_req(REQ_PASS, FRAME_MAX);
		end_burst();
		set_grid(524287, 131071, 131071, 131071, 2, 3);
		send_req(REQ_FWD, 48'd100);
		send_req(REQ_BACK, 48'd100);
		end_burst();
	endtask

	task automatic test_random_grid();
		for (int ph = 0; ph < 15; ph++) begin
			set_grid($urandom_range(0, 9) == 0 ? $urandom_range(0, 524287)
					: $urandom_range(1, 384000),
				$urandom_range(0, 9) == 0 ? $urandom_range(0, 131071)
					: $urandom_range(1, 99999),
				$urandom_range(0, 4) == 0 ? $urandom_range(1, 99999) : $urandom_range(1, 3000),
				$urandom_range(0, 4) == 0 ? $urandom_range(1, 131071)
					: $urandom_range(30000, 99999),
				$urandom_range(0, 31), $urandom_range(0, 15));
			for (int i = 0; i < 30; i++) send_req(pick_req(), pick_frame());
			end_burst();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
		start = 1'b0; req_type = REQ_SNAP; frame_in = '0;
		mismatches = 0;
		burst_left = 0;
		m_rate = RATE_RST; m_tempo = TEMPO_RST; m_t_lo = T_LO_RST;
		m_t_hi = T_HI_RST; m_beats = BEATS_RST; m_div = DIV_RST;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		test_directed();
		test_extreme_settings();
		test_random_grid();
		settle();
		if (mismatches == 0 && pending_hits.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule

### filelist.f
sv/tgq_pkg.sv
sv/tgq_unit_calc.sv
sv/tgq_div_cell.sv
sv/tempo_grid_frame_quantizer_unit.sv
sv/tgq_checker.sv
bench/tb_tempo_grid_frame_quantizer_unit.sv
